// ===== src/hcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types, character codes and helper functions of the HTTP chunked
// body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

   // Default width of the chunk size and of the chunk byte counter
   localparam int SIZE_BITS_DEFAULT = 32;

   // Character codes
   localparam logic [7:0] CHAR_LBRACE  = 8'h7B;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;

   // Bits added to the size by one hex digit
   localparam int HEX_DIGIT_BITS = 4;

   // Bytes dropped after the payload of a chunk (CR and LF)
   localparam logic [1:0] CRLF_BYTES = 2'd2;

   // Decoding phase of the body
   typedef enum logic [2:0] {
      PH_UNDECIDED = 3'd0,
      PH_IDENTITY  = 3'd1,
      PH_SIZE_LINE = 3'd2,
      PH_PAYLOAD   = 3'd3,
      PH_CRLF      = 3'd4,
      PH_FINISHED  = 3'd5
   } phase_type;

   // Position within a chunk size line
   typedef enum logic [1:0] {
      ST_LEAD   = 2'd0,
      ST_SIGN   = 2'd1,
      ST_DIGITS = 2'd2,
      ST_REST   = 2'd3
   } line_stage_type;

   // One input transaction
   typedef struct packed {
      logic [7:0] in_byte;
      logic       source_closed;
   } item_type;

   // One result transaction
   typedef struct packed {
      logic [7:0] out_byte;
      logic       body_end;
   } result_type;

   // Hex digit decode: bit 4 flags a hex character, bits 3:0 carry its value
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

   // White space skipped before the sign or digits: space, tab, CR, VT, FF
   function automatic logic is_blank(input logic [7:0] b);
      return (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) ||
             (b == 8'h0B) || (b == 8'h0C);
   endfunction

endpackage

// ===== src/hcbd_req_if.sv =====
// ----------------------------------------------------------------------------
// hcbd_req_if
// Input channel of the decoder: one raw body byte or a close indication per
// transaction.
// ----------------------------------------------------------------------------
interface hcbd_req_if;

   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       source_closed;

   modport source (output valid, output in_byte, output source_closed, input ready);
   modport sink   (input valid, input in_byte, input source_closed, output ready);

endinterface

// ===== src/hcbd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// hcbd_rsp_if
// Result channel of the decoder: one payload byte or the end-of-body mark per
// transaction.
// ----------------------------------------------------------------------------
interface hcbd_rsp_if;

   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       body_end;

   modport source (output valid, output out_byte, output body_end, input ready);
   modport sink   (input valid, input out_byte, input body_end, output ready);

endinterface

// ===== src/hcbd_step.sv =====
// ----------------------------------------------------------------------------
// hcbd_step
// Decoder state and the state update for one body byte: framing choice, size
// line parse with saturation, payload count and CRLF drop.
// ----------------------------------------------------------------------------
module hcbd_step #(
   parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  hcbd_pkg::item_type   item,
   output logic                 res_valid,
   output hcbd_pkg::result_type res
);

   import hcbd_pkg::*;

   phase_type            phase_ff,      phase_in;
   logic [SIZE_BITS-1:0] chunk_left_ff, chunk_left_in;
   logic [SIZE_BITS-1:0] size_value_ff, size_value_in;
   line_stage_type       stage_ff,      stage_in;
   logic                 negative_ff,   negative_in;
   logic [1:0]           crlf_left_ff,  crlf_left_in;

   // Register the decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_UNDECIDED;
         chunk_left_ff <= '0;
         size_value_ff <= '0;
         stage_ff      <= ST_LEAD;
         negative_ff   <= 1'b0;
         crlf_left_ff  <= 2'd0;
      end else begin
         phase_ff      <= phase_in;
         chunk_left_ff <= chunk_left_in;
         size_value_ff <= size_value_in;
         stage_ff      <= stage_in;
         negative_ff   <= negative_in;
         crlf_left_ff  <= crlf_left_in;
      end
   end

   // Work out next state and result for the byte in the input register
   always_comb begin
      phase_type                           eff_phase;
      logic [SIZE_BITS-1:0]                line_value;
      line_stage_type                      line_stage;
      logic                                line_neg;
      logic [4:0]                          hex;
      logic [SIZE_BITS+HEX_DIGIT_BITS-1:0] shifted;
      logic [SIZE_BITS-1:0]                added;
      logic [SIZE_BITS-1:0]                chunk_dec;
      logic [1:0]                          crlf_dec;
      logic [7:0]                          b;

      b          = item.in_byte;
      hex        = hex_decode(b);
      eff_phase  = phase_ff;
      line_value = size_value_ff;
      line_stage = stage_ff;
      line_neg   = negative_ff;

      phase_in      = phase_ff;
      chunk_left_in = chunk_left_ff;
      size_value_in = size_value_ff;
      stage_in      = stage_ff;
      negative_in   = negative_ff;
      crlf_left_in  = crlf_left_ff;
      res_valid     = 1'b0;
      res.out_byte  = b;
      res.body_end  = 1'b0;

      // Append one hex digit, saturate when any bit is shifted out
      shifted = {line_value, hex[3:0]};
      if (shifted[SIZE_BITS+HEX_DIGIT_BITS-1 -: HEX_DIGIT_BITS] != '0) begin
         added = '1;
      end else begin
         added = shifted[SIZE_BITS-1:0];
      end

      chunk_dec = (chunk_left_ff != '0) ? chunk_left_ff - SIZE_BITS'(1) : chunk_left_ff;
      crlf_dec  = (crlf_left_ff != 2'd0) ? crlf_left_ff - 2'd1 : crlf_left_ff;

      if (fire && phase_ff != PH_FINISHED) begin
         if (item.source_closed) begin
            // Close ends the body wherever it stands
            phase_in     = PH_FINISHED;
            res_valid    = 1'b1;
            res.out_byte = 8'd0;
            res.body_end = 1'b1;
         end else begin
            // First byte picks the framing
            if (phase_ff == PH_UNDECIDED) begin
               if (b == CHAR_LBRACE) begin
                  eff_phase = PH_IDENTITY;
               end else begin
                  eff_phase  = PH_SIZE_LINE;
                  line_value = '0;
                  line_stage = ST_LEAD;
                  line_neg   = 1'b0;
               end
            end

            unique case (eff_phase)
               PH_IDENTITY: begin
                  phase_in  = PH_IDENTITY;
                  res_valid = 1'b1;
               end
               PH_SIZE_LINE: begin
                  phase_in      = PH_SIZE_LINE;
                  size_value_in = line_value;
                  stage_in      = line_stage;
                  negative_in   = line_neg;
                  if (b == CHAR_NEWLINE) begin
                     if (line_neg || line_value == '0) begin
                        phase_in     = PH_FINISHED;
                        res_valid    = 1'b1;
                        res.out_byte = 8'd0;
                        res.body_end = 1'b1;
                     end else begin
                        chunk_left_in = line_value;
                        size_value_in = '0;
                        stage_in      = ST_LEAD;
                        negative_in   = 1'b0;
                        phase_in      = PH_PAYLOAD;
                     end
                  end else begin
                     unique case (line_stage)
                        ST_LEAD: begin
                           if (is_blank(b)) begin
                              stage_in = ST_LEAD;
                           end else if (b == CHAR_PLUS || b == CHAR_MINUS) begin
                              negative_in = (b == CHAR_MINUS);
                              stage_in    = ST_SIGN;
                           end else if (hex[4]) begin
                              size_value_in = SIZE_BITS'(hex[3:0]);
                              stage_in      = ST_DIGITS;
                           end else begin
                              stage_in = ST_REST;
                           end
                        end
                        ST_SIGN, ST_DIGITS: begin
                           if (hex[4]) begin
                              size_value_in = added;
                              stage_in      = ST_DIGITS;
                           end else begin
                              stage_in = ST_REST;
                           end
                        end
                        default: begin
                           stage_in = ST_REST;
                        end
                     endcase
                  end
               end
               PH_PAYLOAD: begin
                  res_valid     = 1'b1;
                  chunk_left_in = chunk_dec;
                  if (chunk_dec == '0) begin
                     crlf_left_in = CRLF_BYTES;
                     phase_in     = PH_CRLF;
                  end
               end
               PH_CRLF: begin
                  crlf_left_in = crlf_dec;
                  if (crlf_dec == 2'd0) begin
                     size_value_in = '0;
                     stage_in      = ST_LEAD;
                     negative_in   = 1'b0;
                     phase_in      = PH_SIZE_LINE;
                  end
               end
               default: begin
                  phase_in = PH_FINISHED;
               end
            endcase
         end
      end
   end

`ifndef SYNTHESIS
   // A chunk in progress always has bytes left
   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> chunk_left_ff != '0)
      else $error("payload phase with empty chunk counter");

   // The CRLF skip always has bytes left to drop
   a_crlf_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_CRLF |-> crlf_left_ff != 2'd0)
      else $error("CRLF phase with no bytes left");

   // Nothing comes out once the body has ended
   a_quiet_after_end: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_FINISHED |-> !res_valid)
      else $error("result after end of body");

   // An end mark moves the decoder to finished
   a_end_finishes: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.body_end |=> phase_ff == PH_FINISHED)
      else $error("end mark without finished phase");

   // An end mark carries a zero byte
   a_end_zero_byte: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.body_end |-> res.out_byte == 8'd0)
      else $error("end mark with nonzero byte");
`endif

endmodule

// ===== src/http_chunked_body_decoder_top.sv =====
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top
// HTTP body decoder: identity or chunked framing, one byte per cycle while rsp is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   req carries raw body bytes (in_byte) or a close indication
//   (source_closed = 1, in_byte ignored). rsp carries decoded payload bytes
//   (body_end = 0) and, once, the end-of-body mark (body_end = 1,
//   out_byte = 0). Framing bytes (size lines, CRLF) produce no transaction.
//   Path: a transaction accepted into the input register is processed by the
//   step unit and its result is registered in the output register for rsp.
//   Throughput: one byte per cycle while the receiver does not stall; every
//   byte updates the decoder state once.
//   Reset: clears the input and output registers and returns the decoder to
//   the undecided framing state; req.ready is high from the first reset edge.
//   Receiver stall: the output register holds its result, the input register
//   holds the next byte and req.ready drops until rsp.ready returns.
//   After the end mark no further results appear; bytes are still accepted
//   and dropped.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_top #(
   parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   hcbd_req_if.sink   req,
   hcbd_rsp_if.source rsp
);

   import hcbd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_item_ff;
   logic       advance;
   logic       res_valid;
   result_type res;

   // Move the held byte on when the output slot is free or being emptied
   assign advance     = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready   = !in_valid_ff || advance;
   assign in_valid_in = req.valid ? 1'b1 : (in_valid_ff && !advance);

   // Capture the input transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= req.ready ? in_valid_in : in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_item_ff.in_byte       <= req.in_byte;
         in_item_ff.source_closed <= req.source_closed;
      end
   end

   hcbd_step #(
      .SIZE_BITS(SIZE_BITS)
   ) u_step (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .item      (in_item_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   // Load a new result or drop the delivered one
   always_comb begin
      if (advance) begin
         out_valid_in = res_valid;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         out_item_ff <= res;
      end
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.out_byte = out_item_ff.out_byte;
   assign rsp.body_end = out_item_ff.body_end;

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the HTTP chunked body decoder. One body is decoded
// per run: usually chunked, now and then identity. A byte-level predictor
// tracks the framing state. Every payload byte and the single end-of-body mark
// are checked against it in order. Sender gaps and receiver stalls change
// over the run.
// ----------------------------------------------------------------------------
module testbench;
   import hcbd_pkg::*;

   localparam int SIZE_BITS = SIZE_BITS_DEFAULT;
   localparam int TARGET_ITEMS = 1300;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_X     = 8'h78;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_EQUAL = 8'h3D;

   // White space that a size line may start with
   localparam logic [7:0] BLANK_CHARS [0:4] = '{8'h20, 8'h09, 8'h0D, 8'h0B, 8'h0C};

   // Opening chunk: every blank, a plus sign, a leading zero, an extension,
   // then byte extremes as payload and a non-CRLF pair to be dropped
   localparam logic [7:0] OPENING_CHUNK [0:25] = '{
      8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D, 8'h2B, 8'h30, 8'h63, 8'h3B, 8'h35, 8'h0D, 8'h0A,
      8'h00, 8'hFF, 8'h0A, 8'h7B, 8'h55, 8'hAA, 8'h80, 8'h7F, 8'h0D, 8'h2D, 8'h01, 8'hFE,
      8'h7B, 8'h0A};

   // -------------------------------------------------------------------------
   // Decoder predictor and store of expected output transactions
   // -------------------------------------------------------------------------
   class chunk_decode_board;
      phase_type             phase;
      logic [SIZE_BITS-1:0]  chunk_left;
      logic [SIZE_BITS-1:0]  size_value;
      line_stage_type        stage;
      logic                  negative;
      logic [1:0]            crlf_left;
      result_type            pending_bytes [$];
      int                    fail_count;

      function new();
         phase = PH_UNDECIDED;
         chunk_left = '0;
         crlf_left = 2'd0;
         fail_count = 0;
         clear_line();
      endfunction

      function void clear_line();
         size_value = '0;
         stage = ST_LEAD;
         negative = 1'b0;
      endfunction

      function void end_body();
         phase = PH_FINISHED;
         pending_bytes.push_back({8'h00, 1'b1});
      endfunction

      // Advance the decoder by one accepted input transaction
      function void note_byte(item_type it);
         logic [7:0]           b;
         logic                 hex_ok;
         logic [3:0]           digit;
         logic [SIZE_BITS+3:0] grown;
         b = it.in_byte;
         if (phase == PH_FINISHED) return;
         if (it.source_closed) begin
            end_body();
            return;
         end
         if (phase == PH_UNDECIDED) begin
            if (b == CHAR_LBRACE) begin
               phase = PH_IDENTITY;
            end else begin
               phase = PH_SIZE_LINE;
               clear_line();
            end
         end

         // Decode a hex digit; the low nibble holds the value of 0-9
         hex_ok = 1'b1;
         digit = b[3:0];
         if (b >= 8'h61 && b <= 8'h66 || b >= 8'h41 && b <= 8'h46) begin
            digit = b[3:0] + 4'd9;
         end else if (!(b >= 8'h30 && b <= 8'h39)) begin
            hex_ok = 1'b0;
         end

         case (phase)
            PH_IDENTITY: begin
               pending_bytes.push_back({b, 1'b0});
            end
            PH_SIZE_LINE: begin
               if (b == CHAR_NEWLINE) begin
                  if (negative || size_value == '0) begin
                     end_body();
                  end else begin
                     chunk_left = size_value;
                     clear_line();
                     phase = PH_PAYLOAD;
                  end
               end else begin
                  case (stage)
                     ST_LEAD: begin
                        if (b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0B ||
                            b == 8'h0C) begin
                           // skip leading white space
                        end else if (b == CHAR_PLUS || b == CHAR_MINUS) begin
                           negative = (b == CHAR_MINUS);
                           stage = ST_SIGN;
                        end else if (hex_ok) begin
                           size_value = {{(SIZE_BITS-4){1'b0}}, digit};
                           stage = ST_DIGITS;
                        end else begin
                           stage = ST_REST;
                        end
                     end
                     ST_SIGN, ST_DIGITS: begin
                        if (hex_ok) begin
                           // Saturate once a digit would carry past the top bit
                           grown = ({4'd0, size_value} << HEX_DIGIT_BITS) |
                                   {{SIZE_BITS{1'b0}}, digit};
                           if (grown[SIZE_BITS+3:SIZE_BITS] != 4'd0) begin
                              size_value = '1;
                           end else begin
                              size_value = grown[SIZE_BITS-1:0];
                           end
                           stage = ST_DIGITS;
                        end else begin
                           stage = ST_REST;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            PH_PAYLOAD: begin
               pending_bytes.push_back({b, 1'b0});
               if (chunk_left != '0) chunk_left = chunk_left - 1'b1;
               if (chunk_left == '0) begin
                  crlf_left = CRLF_BYTES;
                  phase = PH_CRLF;
               end
            end
            PH_CRLF: begin
               if (crlf_left != 2'd0) crlf_left = crlf_left - 2'd1;
               if (crlf_left == 2'd0) begin
                  clear_line();
                  phase = PH_SIZE_LINE;
               end
            end
            default: begin
               phase = PH_FINISHED;
            end
         endcase
      endfunction

      // Compare one output transaction with the oldest expectation
      function void check_output(result_type got);
         result_type want;
         if (pending_bytes.size() == 0) begin
            $display("%0t: unexpected output out_byte=%02h body_end=%0b",
                     $time, got.out_byte, got.body_end);
            fail_count++;
            return;
         end
         want = pending_bytes.pop_front();
         if (got.out_byte !== want.out_byte) begin
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, want.out_byte, got.out_byte);
            fail_count++;
         end
         if (got.body_end !== want.body_end) begin
            $display("%0t: body_end mismatch: expected %0b, actual %0b",
                     $time, want.body_end, got.body_end);
            fail_count++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   hcbd_req_if req_chan ();
   hcbd_rsp_if rsp_chan ();

   http_chunked_body_decoder_top #(.SIZE_BITS(SIZE_BITS)) uut (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

   chunk_decode_board board;
   item_type          body_bytes [$];
   int                drive_mode = 0;   // 0 none, 1 sender idle, 2 receiver stall, 3 both

   // Clock: period of 20
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Stimulus construction
   // -------------------------------------------------------------------------
   function void put_byte(logic [7:0] b);
      body_bytes.push_back({b, 1'b0});
   endfunction

   function void put_close();
      body_bytes.push_back({8'($urandom), 1'b1});
   endfunction

   function void put_hex_digit(logic [3:0] nib);
      if (nib < 4'd10) begin
         put_byte(CHAR_ZERO + 8'(nib));
      end else if ($urandom_range(0, 1) == 1) begin
         put_byte(8'h37 + 8'(nib));
      end else begin
         put_byte(8'h57 + 8'(nib));
      end
   endfunction

   function void put_leading_blanks();
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) put_byte(BLANK_CHARS[$urandom_range(0, 4)]);
      end
   endfunction

   // Append bytes that end a size line: maybe an extension, maybe CR, then LF
   function void put_line_tail();
      logic [7:0] b;
      if ($urandom_range(0, 3) == 0) begin
         put_byte($urandom_range(0, 3) == 0 ? CHAR_SEMI : 8'($urandom_range(8'h67, 8'h7E)));
         repeat ($urandom_range(0, 4)) begin
            b = 8'($urandom);
            put_byte(b == CHAR_NEWLINE ? CHAR_EQUAL : b);
         end
      end
      if ($urandom_range(0, 1) == 1) put_byte(CHAR_CR);
      put_byte(CHAR_NEWLINE);
   endfunction

   // Append a size line for a positive size, with random decoration
   function void put_size_line(logic [SIZE_BITS-1:0] value);
      int                   nd;
      logic [SIZE_BITS-1:0] v;
      put_leading_blanks();
      if ($urandom_range(0, 3) == 0) put_byte(CHAR_PLUS);
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) put_byte(CHAR_ZERO);
      nd = 1;
      v = value >> 4;
      while (v != '0) begin
         nd++;
         v = v >> 4;
      end
      for (int k = nd - 1; k >= 0; k--) put_hex_digit(value[4*k +: 4]);
      put_line_tail();
   endfunction

   function void put_chunk(int len);
      put_size_line(SIZE_BITS'(len));
      repeat (len) put_byte(8'($urandom));
      if ($urandom_range(0, 4) == 0) begin
         put_byte(8'($urandom));
         put_byte(8'($urandom));
      end else begin
         put_byte(CHAR_CR);
         put_byte(CHAR_NEWLINE);
      end
   endfunction

   // Append one of the ways a chunked body can end
   function void put_body_end();
      int len;
      case ($urandom_range(0, 8))
         0: begin
            // size saturates; stream payload, then close mid-chunk
            put_leading_blanks();
            put_hex_digit(4'($urandom_range(1, 15)));
            repeat ($urandom_range(8, 12)) put_hex_digit(4'($urandom));
            put_line_tail();
            repeat ($urandom_range(5, 40)) put_byte(8'($urandom));
            put_close();
         end
         1: begin
            put_leading_blanks();
            put_byte(CHAR_MINUS);
            repeat ($urandom_range(0, 4)) put_hex_digit(4'($urandom));
            put_line_tail();
         end
         2: begin
            put_leading_blanks();
            put_line_tail();
         end
         3: begin
            put_byte($urandom_range(0, 1) == 1 ? CHAR_PLUS : CHAR_MINUS);
            put_byte(BLANK_CHARS[0]);
            put_hex_digit(4'($urandom_range(1, 15)));
            put_line_tail();
         end
         4: begin
            put_byte(CHAR_ZERO);
            put_byte(CHAR_X);
            put_hex_digit(4'($urandom_range(1, 15)));
            put_hex_digit(4'($urandom));
            put_line_tail();
         end
         5: begin
            repeat ($urandom_range(1, 3)) put_byte(CHAR_ZERO);
            put_line_tail();
         end
         6: begin
            // close inside a size line
            put_leading_blanks();
            put_hex_digit(4'($urandom_range(1, 15)));
            put_close();
         end
         7: begin
            // close inside the dropped pair
            len = $urandom_range(1, 8);
            put_size_line(SIZE_BITS'(len));
            repeat (len) put_byte(8'($urandom));
            put_byte(CHAR_CR);
            put_close();
         end
         default: begin
            // close inside a chunk payload
            put_size_line(SIZE_BITS'($urandom_range(4, 20)));
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
            put_close();
         end
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Input driver
   // -------------------------------------------------------------------------
   task automatic send_body();
      int idle_pct;
      for (int i = 0; i < body_bytes.size(); i++) begin
         drive_mode = (i * 4) / body_bytes.size();
         idle_pct = (drive_mode == 1) ? 84 : (drive_mode == 3) ? 20 : 0;
         // Hold off for a random gap
         while ($urandom_range(0, 99) < idle_pct) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
         req_chan.valid         <= 1'b1;
         req_chan.in_byte       <= body_bytes[i].in_byte;
         req_chan.source_closed <= body_bytes[i].source_closed;
         @(posedge clock);
         while (!req_chan.ready) @(posedge clock);
         board.note_byte(body_bytes[i]);
      end
      req_chan.valid <= 1'b0;
      drive_mode = 0;
   endtask

   // -------------------------------------------------------------------------
   // Output monitor: check each transaction, then pick the next ready
   // -------------------------------------------------------------------------
   initial begin
      int stall_pct;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            board.check_output({rsp_chan.out_byte, rsp_chan.body_end});
         end
         stall_pct = (drive_mode == 2) ? 84 : (drive_mode == 3) ? 20 : 0;
         rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int waited;
      board = new();
      reset <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.in_byte       <= 8'h00;
      req_chan.source_closed <= 1'b0;

      // Build the body: mostly chunked, sometimes identity
      if ($urandom_range(0, 9) == 0) begin
         put_byte(CHAR_LBRACE);
         for (int i = 12; i < 24; i++) put_byte(OPENING_CHUNK[i]);
         while (body_bytes.size() < TARGET_ITEMS) put_byte(8'($urandom));
         put_close();
      end else begin
         foreach (OPENING_CHUNK[i]) put_byte(OPENING_CHUNK[i]);
         while (body_bytes.size() < TARGET_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
               put_chunk($urandom_range(17, 300));
            end else begin
               put_chunk($urandom_range(1, 16));
            end
         end
         put_body_end();
      end
      // Trailing bytes and closes after the end are dropped
      repeat (30) begin
         if ($urandom_range(0, 3) == 0) begin
            put_close();
         end else begin
            put_byte(8'($urandom));
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      send_body();

      // Drain, then allow for the pipeline latency
      waited = 0;
      while (board.pending_bytes.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (board.pending_bytes.size() != 0) begin
         $display("%0t: %0d expected output transactions never arrived",
                  $time, board.pending_bytes.size());
         board.fail_count++;
      end
      if (board.fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #8000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
